[rtl/pda_pkg.sv]
`timescale 1ns / 1ps
package pda_pkg;

  localparam int PROB_FRAC_BITS = 24;
  localparam int ACC_WIDTH      = 64;
  localparam int PROB_W         = 25;
  localparam int SUM_W          = PROB_W + 1;
  localparam int OUT_W          = 48;

  // digit-by-digit square root of p << PROB_FRAC_BITS
  localparam int RAD_W      = PROB_W + PROB_FRAC_BITS;
  localparam int SQRT_STEPS = (RAD_W + 1) / 2;
  localparam int RAD_E      = 2 * SQRT_STEPS;
  localparam int ROOT_W     = SQRT_STEPS;
  localparam int REM_W      = SQRT_STEPS + 3;

  // log2 with integer part and fraction
  localparam int LOG_FRAC  = 30;
  localparam int LOG_INT_W = 5;
  localparam int LOG_W     = LOG_INT_W + LOG_FRAC;
  localparam int DIFF_W    = LOG_W + 2;
  localparam int MAG_W     = LOG_W + 1;
  localparam int MANT_W    = 32;

  localparam int MUL_W  = 32;
  localparam int PROD_W = 2 * MUL_W;
  localparam int LN_SH  = 28;
  localparam logic [MUL_W-1:0] LN2_Q28 = 32'd186065279;

  localparam int CNT_W       = 5;
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = 1;
  localparam int QCNT_W      = 2;

  // log and term selector codes
  localparam logic [1:0] SEL_FIRST  = 2'd0;
  localparam logic [1:0] SEL_SECOND = 2'd1;
  localparam logic [1:0] SEL_TOTAL  = 2'd2;

  typedef struct packed {
    logic [PROB_W-1:0] p1;
    logic [PROB_W-1:0] p2;
    logic [SUM_W-1:0]  total;
    logic              p1_nz;
    logic              p2_nz;
    logic              last;
  } item_t;

  typedef struct packed {
    logic [REM_W-1:0]  rem;
    logic [ROOT_W-1:0] root;
  } sqrt_t;

  typedef enum logic [3:0] {
    B_IDLE,
    B_SQRT,
    B_HEL_MUL,
    B_HEL_ACC,
    B_LOG_INIT,
    B_LOG,
    B_LN_LO,
    B_LN_HI,
    B_TERM_LO,
    B_TERM_HI,
    B_ACC,
    B_EMIT
  } back_state_t;

endpackage

[rtl/probability_divergence_accumulator_core.sv]
`timescale 1ns / 1ps
// channel   direction  handshake                 payload
// item      in         item_valid / item_stall   prob_first, prob_second, last_item
// result    out        result_valid / result_stall
//                                                hellinger_dist, kl_divergence,
//                                                js_divergence, kl_infinite
//
// each request in the back end runs the two square roots side by side, then
// three log2 runs and five steps per term on the one shared 32x32 multiplier,
// with an emit step added on a last item
// rst is synchronous and clears the sums, the queue and result_valid
// a two-entry queue lets requests be taken while the back end is busy
// a held result stalls only the emit step of the next last item
module probability_divergence_accumulator_core import pda_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    item_valid,
  output logic                    item_stall,
  input  logic [PROB_W-1:0]       prob_first,
  input  logic [PROB_W-1:0]       prob_second,
  input  logic                    last_item,
  output logic                    result_valid,
  input  logic                    result_stall,
  output logic signed [OUT_W-1:0] hellinger_dist,
  output logic signed [OUT_W-1:0] kl_divergence,
  output logic signed [OUT_W-1:0] js_divergence,
  output logic                    kl_infinite
);

  item_t f_item, q_item;
  logic  f_valid, f_full, q_valid, q_pop;

  pda_front u_front (
    .clk, .rst, .item_valid, .item_stall, .prob_first, .prob_second, .last_item,
    .f_item, .f_valid, .f_full
  );

  pda_queue u_queue (
    .clk, .rst, .f_item, .f_valid, .f_full, .q_item, .q_valid, .q_pop
  );

  pda_back u_back (
    .clk, .rst, .q_item, .q_valid, .q_pop, .hellinger_dist, .kl_divergence,
    .js_divergence, .kl_infinite, .result_valid, .result_stall
  );

endmodule

[rtl/pda_front.sv]
`timescale 1ns / 1ps
module pda_front import pda_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              item_valid,
  output logic              item_stall,
  input  logic [PROB_W-1:0] prob_first,
  input  logic [PROB_W-1:0] prob_second,
  input  logic              last_item,
  output item_t             f_item,
  output logic              f_valid,
  input  logic              f_full
);

  logic load;

  assign item_stall = f_valid && f_full;
  assign load       = item_valid && !item_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      f_valid <= 1'b0;
    end else if (load) begin
      f_valid <= 1'b1;
    end else if (!f_full) begin
      f_valid <= 1'b0;
    end
    if (load) begin
      f_item.p1    <= prob_first;
      f_item.p2    <= prob_second;
      f_item.total <= SUM_W'(prob_first) + SUM_W'(prob_second);
      f_item.p1_nz <= (prob_first != '0);
      f_item.p2_nz <= (prob_second != '0);
      f_item.last  <= last_item;
    end
  end

endmodule

[rtl/pda_queue.sv]
`timescale 1ns / 1ps
module pda_queue import pda_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  item_t f_item,
  input  logic  f_valid,
  output logic  f_full,
  output item_t q_item,
  output logic  q_valid,
  input  logic  q_pop
);

  item_t             slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;
  logic              push;
  logic              pop;

  assign f_full  = (count == QCNT_W'(QUEUE_DEPTH));
  assign q_valid = (count != '0);
  assign q_item  = slots[rd_ptr];
  assign push    = f_valid && !f_full;
  assign pop     = q_pop && q_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
    if (push) slots[wr_ptr] <= f_item;
  end

endmodule

[rtl/pda_back.sv]
`timescale 1ns / 1ps
module pda_back import pda_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  input  item_t                   q_item,
  input  logic                    q_valid,
  output logic                    q_pop,
  output logic signed [OUT_W-1:0] hellinger_dist,
  output logic signed [OUT_W-1:0] kl_divergence,
  output logic signed [OUT_W-1:0] js_divergence,
  output logic                    kl_infinite,
  output logic                    result_valid,
  input  logic                    result_stall
);

  localparam logic signed [ACC_WIDTH-1:0] ACC_MAX = {1'b0, {(ACC_WIDTH-1){1'b1}}};
  localparam logic signed [ACC_WIDTH-1:0] ACC_MIN = {1'b1, {(ACC_WIDTH-1){1'b0}}};
  localparam logic signed [ACC_WIDTH-1:0] OUT_MAX = ACC_WIDTH'({1'b0, {(OUT_W-1){1'b1}}});
  localparam logic signed [ACC_WIDTH-1:0] OUT_MIN = -OUT_MAX - ACC_WIDTH'(1);
  localparam logic [DIFF_W-1:0] LOG_ONE = DIFF_W'(1) << LOG_FRAC;

  function automatic sqrt_t sqrt_step(input sqrt_t s, input logic [1:0] two);
    logic [REM_W-1:0] r;
    logic [REM_W-1:0] trial;
    sqrt_t            o;
    r     = {s.rem[REM_W-3:0], two};
    trial = REM_W'({s.root, 2'b01});
    if (r >= trial) begin
      o.rem  = r - trial;
      o.root = {s.root[ROOT_W-2:0], 1'b1};
    end else begin
      o.rem  = r;
      o.root = {s.root[ROOT_W-2:0], 1'b0};
    end
    return o;
  endfunction

  function automatic logic signed [ACC_WIDTH-1:0] sat_add(
    input logic signed [ACC_WIDTH-1:0] a, input logic signed [ACC_WIDTH-1:0] t);
    logic signed [ACC_WIDTH:0] s;
    s = {a[ACC_WIDTH-1], a} + {t[ACC_WIDTH-1], t};
    if (s[ACC_WIDTH] != s[ACC_WIDTH-1]) return s[ACC_WIDTH] ? ACC_MIN : ACC_MAX;
    return s[ACC_WIDTH-1:0];
  endfunction

  function automatic logic signed [OUT_W-1:0] sat_out(input logic signed [ACC_WIDTH-1:0] v);
    if (v > OUT_MAX) return OUT_MAX[OUT_W-1:0];
    if (v < OUT_MIN) return OUT_MIN[OUT_W-1:0];
    return v[OUT_W-1:0];
  endfunction

  back_state_t state, state_next;

  item_t                        cur;
  logic [CNT_W-1:0]             cnt;
  logic [1:0]                   sel;
  logic [RAD_E-1:0]             rad1, rad2;
  sqrt_t                        sq1, sq2;
  logic [MANT_W-1:0]            mant;
  logic [LOG_INT_W-1:0]         lg_int;
  logic [LOG_FRAC-1:0]          frac;
  logic [LOG_W-1:0]             lg_p1, lg_p2, lg_sum;
  logic [PROD_W-1:0]            prod;
  logic [MAG_W-1:0]             lnmag;
  logic                         neg;
  logic signed [ACC_WIDTH-1:0]  hel_sum, kl_sum, js1_sum, js2_sum;
  logic                         inf_seen;

  logic [MUL_W-1:0]             mul_a, mul_b;
  logic [PROD_W-1:0]            mul_p;
  logic                         out_load;
  logic [ROOT_W-1:0]            root_diff;
  logic [SUM_W-1:0]             log_x;
  logic [LOG_INT_W-1:0]         n_init;
  logic [MANT_W-1:0]            m_init;
  logic [MANT_W:0]              sq_top;
  logic                         frac_bit;
  logic [MANT_W-1:0]            m_step;
  logic [LOG_FRAC-1:0]          frac_step;
  logic [LOG_W-1:0]             la, lb;
  logic [DIFF_W-1:0]            diff;
  logic [MAG_W-1:0]             dmag;
  logic [MUL_W-1:0]             p_sel;
  logic signed [ACC_WIDTH-1:0]  tmag, term;
  logic signed [ACC_WIDTH:0]    js_tot;
  logic signed [ACC_WIDTH-1:0]  hel_half, js_half;

  assign mul_p = {{(PROD_W-MUL_W){1'b0}}, mul_a} * {{(PROD_W-MUL_W){1'b0}}, mul_b};

  // root difference
  assign root_diff = (sq1.root > sq2.root) ? sq1.root - sq2.root : sq2.root - sq1.root;

  // log2 normalise
  always_comb begin
    case (sel)
      SEL_FIRST:  log_x = SUM_W'(cur.p1);
      SEL_SECOND: log_x = SUM_W'(cur.p2);
      default:    log_x = cur.total;
    endcase
    n_init = '0;
    for (int i = 0; i < SUM_W; i++) begin
      if (log_x[i]) n_init = LOG_INT_W'(i);
    end
    m_init = MANT_W'(log_x) << (LOG_INT_W'(MANT_W - 1) - n_init);
  end

  assign sq_top    = mul_p[PROD_W-1:MANT_W-1];
  assign frac_bit  = sq_top[MANT_W];
  assign m_step    = frac_bit ? sq_top[MANT_W:1] : sq_top[MANT_W-1:0];
  assign frac_step = {frac[LOG_FRAC-2:0], frac_bit};

  // log difference for the selected term, 2*p adds one to log2
  always_comb begin
    la   = (sel == SEL_TOTAL) ? lg_p2 : lg_p1;
    lb   = (sel == SEL_FIRST) ? lg_p2 : lg_sum;
    diff = DIFF_W'(la) - DIFF_W'(lb) + ((sel != SEL_FIRST) ? LOG_ONE : '0);
    dmag = diff[DIFF_W-1] ? MAG_W'(-diff) : MAG_W'(diff);
  end

  assign p_sel = (sel == SEL_TOTAL) ? MUL_W'(cur.p2) : MUL_W'(cur.p1);
  assign tmag  = ACC_WIDTH'(prod >> LOG_FRAC);
  assign term  = neg ? -tmag : tmag;

  assign js_tot   = {js1_sum[ACC_WIDTH-1], js1_sum} + {js2_sum[ACC_WIDTH-1], js2_sum};
  assign js_half  = js_tot[ACC_WIDTH:1];
  assign hel_half = {hel_sum[ACC_WIDTH-1], hel_sum[ACC_WIDTH-1:1]};

  // next state
  always_comb begin
    state_next = state;
    case (state)
      B_IDLE:     if (q_valid) state_next = B_SQRT;
      B_SQRT:     if (cnt == CNT_W'(SQRT_STEPS - 1)) state_next = B_HEL_MUL;
      B_HEL_MUL:  state_next = B_HEL_ACC;
      B_HEL_ACC:  state_next = B_LOG_INIT;
      B_LOG_INIT: state_next = B_LOG;
      B_LOG: begin
        if (cnt == CNT_W'(LOG_FRAC - 1)) begin
          state_next = (sel == SEL_TOTAL) ? B_LN_LO : B_LOG_INIT;
        end
      end
      B_LN_LO:    state_next = B_LN_HI;
      B_LN_HI:    state_next = B_TERM_LO;
      B_TERM_LO:  state_next = B_TERM_HI;
      B_TERM_HI:  state_next = B_ACC;
      B_ACC: begin
        if (sel != SEL_TOTAL) begin
          state_next = B_LN_LO;
        end else begin
          state_next = cur.last ? B_EMIT : B_IDLE;
        end
      end
      B_EMIT:     if (out_load) state_next = B_IDLE;
      default:    state_next = B_IDLE;
    endcase
  end

  // outputs: queue pop, multiplier operands, result load
  always_comb begin
    q_pop    = 1'b0;
    out_load = 1'b0;
    mul_a    = '0;
    mul_b    = '0;
    case (state)
      B_IDLE:    q_pop = q_valid;
      B_HEL_MUL: begin
        mul_a = MUL_W'(root_diff);
        mul_b = MUL_W'(root_diff);
      end
      B_LOG: begin
        mul_a = mant;
        mul_b = mant;
      end
      B_LN_LO: begin
        mul_a = dmag[MUL_W-1:0];
        mul_b = LN2_Q28;
      end
      B_LN_HI: begin
        mul_a = MUL_W'(dmag[MAG_W-1:MUL_W]);
        mul_b = LN2_Q28;
      end
      B_TERM_LO: begin
        mul_a = prod[LN_SH+MUL_W-1:LN_SH];
        mul_b = p_sel;
      end
      B_TERM_HI: begin
        mul_a = MUL_W'(lnmag[MAG_W-1:MUL_W]);
        mul_b = p_sel;
      end
      B_EMIT:    out_load = !result_valid || !result_stall;
      default:   ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= B_IDLE;
      result_valid <= 1'b0;
      hel_sum      <= '0;
      kl_sum       <= '0;
      js1_sum      <= '0;
      js2_sum      <= '0;
      inf_seen     <= 1'b0;
      sel          <= SEL_FIRST;
      cnt          <= '0;
    end else begin
      state <= state_next;
      if (out_load) begin
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
      case (state)
        B_IDLE: begin
          if (q_valid) begin
            cur  <= q_item;
            rad1 <= RAD_E'({q_item.p1, {PROB_FRAC_BITS{1'b0}}});
            rad2 <= RAD_E'({q_item.p2, {PROB_FRAC_BITS{1'b0}}});
            sq1  <= '0;
            sq2  <= '0;
            cnt  <= '0;
          end
        end
        B_SQRT: begin
          sq1  <= sqrt_step(sq1, rad1[RAD_E-1:RAD_E-2]);
          sq2  <= sqrt_step(sq2, rad2[RAD_E-1:RAD_E-2]);
          rad1 <= rad1 << 2;
          rad2 <= rad2 << 2;
          cnt  <= cnt + 1'b1;
        end
        B_HEL_MUL: prod <= mul_p;
        B_HEL_ACC: begin
          hel_sum <= sat_add(hel_sum, ACC_WIDTH'(prod >> PROB_FRAC_BITS));
          sel     <= SEL_FIRST;
        end
        B_LOG_INIT: begin
          mant   <= m_init;
          lg_int <= n_init;
          frac   <= '0;
          cnt    <= '0;
        end
        B_LOG: begin
          mant <= m_step;
          frac <= frac_step;
          cnt  <= cnt + 1'b1;
          if (cnt == CNT_W'(LOG_FRAC - 1)) begin
            case (sel)
              SEL_FIRST:  lg_p1  <= {lg_int, frac_step};
              SEL_SECOND: lg_p2  <= {lg_int, frac_step};
              default:    lg_sum <= {lg_int, frac_step};
            endcase
            sel <= (sel == SEL_TOTAL) ? SEL_FIRST : sel + 1'b1;
          end
        end
        B_LN_LO: begin
          prod <= mul_p;
          neg  <= diff[DIFF_W-1];
        end
        B_LN_HI:   prod <= prod + {mul_p[MUL_W-1:0], {MUL_W{1'b0}}};
        B_TERM_LO: begin
          lnmag <= prod[LN_SH+MAG_W-1:LN_SH];
          prod  <= mul_p;
        end
        B_TERM_HI: prod <= prod + {mul_p[MUL_W-1:0], {MUL_W{1'b0}}};
        B_ACC: begin
          case (sel)
            SEL_FIRST: begin
              if (cur.p1_nz && cur.p2_nz) kl_sum <= sat_add(kl_sum, term);
              if (cur.p1_nz && !cur.p2_nz) inf_seen <= 1'b1;
            end
            SEL_SECOND: if (cur.p1_nz) js1_sum <= sat_add(js1_sum, term);
            default:    if (cur.p2_nz) js2_sum <= sat_add(js2_sum, term);
          endcase
          sel <= (sel == SEL_TOTAL) ? SEL_FIRST : sel + 1'b1;
        end
        B_EMIT: begin
          if (out_load) begin
            hel_sum  <= '0;
            kl_sum   <= '0;
            js1_sum  <= '0;
            js2_sum  <= '0;
            inf_seen <= 1'b0;
          end
        end
        default: ;
      endcase
    end
    if (out_load) begin
      hellinger_dist <= sat_out(hel_half);
      kl_divergence  <= sat_out(kl_sum);
      js_divergence  <= sat_out(js_half);
      kl_infinite    <= inf_seen;
    end
  end

endmodule

[rtl/pda_checker.sv]
`timescale 1ns / 1ps
module pda_checker import pda_pkg::*; (
  input logic                    clk,
  input logic                    rst,
  input logic                    item_valid,
  input logic                    item_stall,
  input logic [PROB_W-1:0]       prob_first,
  input logic [PROB_W-1:0]       prob_second,
  input logic                    last_item,
  input logic                    result_valid,
  input logic                    result_stall,
  input logic signed [OUT_W-1:0] hellinger_dist,
  input logic signed [OUT_W-1:0] kl_divergence,
  input logic signed [OUT_W-1:0] js_divergence,
  input logic                    kl_infinite
);

  // a stalled request stays on the inputs unchanged
  a_item_held: assert property (@(posedge clk) disable iff (rst)
    item_valid && item_stall |=> item_valid && $stable(prob_first)
      && $stable(prob_second) && $stable(last_item))
    else $error("request changed while stalled");

  a_valid_held: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid)
    else $error("result dropped while stalled");

  a_payload_held: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> $stable(hellinger_dist) && $stable(kl_divergence)
      && $stable(js_divergence) && $stable(kl_infinite))
    else $error("result changed while stalled");

  a_reset_clear: assert property (@(posedge clk) rst |=> !result_valid)
    else $error("result after reset");

  // squared root differences never sum below zero
  a_hel_nonneg: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> !hellinger_dist[OUT_W-1])
    else $error("negative hellinger distance");

endmodule

bind probability_divergence_accumulator_core pda_checker u_pda_checker (.*);

[tb/probability_divergence_accumulator_core_tb.sv]
`timescale 1ns / 1ps
module probability_divergence_accumulator_core_tb;
  import pda_pkg::*;

  localparam int WATCHDOG_LIMIT = 5000;
  localparam int DRAIN_CYCLES   = 400;
  localparam int QUIET_ITEMS    = 300;
  localparam longint unsigned TOP = 64'h8000_0000_0000_0000;
  localparam longint ACC_HI = 64'sh7fff_ffff_ffff_ffff;
  localparam longint ACC_LO = -ACC_HI - 1;
  localparam longint unsigned LN2_FIX = 64'd186065279;

  typedef struct {
    logic [PROB_W-1:0] p1;
    logic [PROB_W-1:0] p2;
    logic              last;
  } pair_t;

  typedef struct {
    logic [OUT_W-1:0] hel;
    logic [OUT_W-1:0] kl;
    logic [OUT_W-1:0] js;
    logic             inf;
  } dist_t;

  logic                    clk = 1'b0;
  logic                    rst = 1'b1;
  logic                    item_valid = 1'b0;
  logic                    item_stall;
  logic [PROB_W-1:0]       prob_first = '0;
  logic [PROB_W-1:0]       prob_second = '0;
  logic                    last_item = 1'b0;
  logic                    result_valid;
  logic                    result_stall = 1'b0;
  logic signed [OUT_W-1:0] hellinger_dist;
  logic signed [OUT_W-1:0] kl_divergence;
  logic signed [OUT_W-1:0] js_divergence;
  logic                    kl_infinite;

  pair_t  pending_pairs[$];
  dist_t  expected_dists[$];
  longint hel_acc = 0, kl_acc = 0, jsa_acc = 0, jsb_acc = 0;
  bit     inf_seen = 0;
  int     mismatches = 0;
  int     idle_cycles = 0;
  int     send_gap = 0, recv_gap = 0;
  bit     req_taken = 0;

  probability_divergence_accumulator_core dut (.*);

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic longint unsigned root_of(longint unsigned v);
    longint unsigned res = 0;
    longint unsigned b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v -= res + b;
        res = (res >> 1) + b;
      end else begin
        res >>= 1;
      end
      b >>= 2;
    end
    return res;
  endfunction

  function automatic longint unsigned log2_of(longint unsigned x);
    int unsigned     n = 0;
    longint unsigned m, frac = 0;
    while (n < 31 && (x >> (n + 1)) != 0) n++;
    m = x << (31 - n);
    for (int i = 0; i < 30; i++) begin
      m = (m * m) >> 31;
      frac <<= 1;
      if (m >= (64'd1 << 32)) begin
        m >>= 1;
        frac |= 1;
      end
    end
    return (longint'(n) << 30) | frac;
  endfunction

  // ln(a/b) with 30 fraction bits, truncated toward zero
  function automatic longint ln_of_ratio(longint unsigned a, longint unsigned b);
    longint          diff = longint'(log2_of(a)) - longint'(log2_of(b));
    longint unsigned mag = diff < 0 ? -diff : diff;
    longint          r = longint'((mag * LN2_FIX) >> 28);
    return diff < 0 ? -r : r;
  endfunction

  function automatic longint weighted(longint unsigned p, longint ln);
    longint unsigned mag = ln < 0 ? -ln : ln;
    longint          r = longint'((p * mag) >> 30);
    return ln < 0 ? -r : r;
  endfunction

  function automatic longint sat_sum(longint a, longint t);
    if (t > 0 && a > ACC_HI - t) return ACC_HI;
    if (t < 0 && a < ACC_LO - t) return ACC_LO;
    return a + t;
  endfunction

  function automatic logic [OUT_W-1:0] clamp_out(longint unsigned u);
    longint unsigned lo = TOP - (64'd1 << 47);
    longint unsigned hi = TOP + (64'd1 << 47) - 1;
    if (u < lo) u = lo;
    if (u > hi) u = hi;
    return OUT_W'(u - TOP);
  endfunction

  // fold one pair into the running sums, queue a result on the last pair
  task automatic fold_pair(logic [PROB_W-1:0] a, logic [PROB_W-1:0] b, logic fin);
    longint unsigned p1 = a, p2 = b;
    longint unsigned s1, s2, d, ua, ub;
    dist_t           r;
    s1 = root_of(p1 << PROB_FRAC_BITS);
    s2 = root_of(p2 << PROB_FRAC_BITS);
    d = s1 > s2 ? s1 - s2 : s2 - s1;
    hel_acc = sat_sum(hel_acc, longint'((d * d) >> PROB_FRAC_BITS));
    if (p1 != 0) begin
      if (p2 != 0) kl_acc = sat_sum(kl_acc, weighted(p1, ln_of_ratio(p1, p2)));
      else inf_seen = 1;
      jsa_acc = sat_sum(jsa_acc, weighted(p1, ln_of_ratio(2 * p1, p1 + p2)));
    end
    if (p2 != 0) jsb_acc = sat_sum(jsb_acc, weighted(p2, ln_of_ratio(2 * p2, p1 + p2)));
    if (fin) begin
      r.hel = clamp_out(longint'(hel_acc >>> 1) ^ TOP);
      r.kl = clamp_out(longint'(kl_acc) ^ TOP);
      ua = longint'(jsa_acc) ^ TOP;
      ub = longint'(jsb_acc) ^ TOP;
      r.js = clamp_out((ua >> 1) + (ub >> 1) + (ua & ub & 1));
      r.inf = inf_seen;
      expected_dists.push_back(r);
      hel_acc = 0; kl_acc = 0; jsa_acc = 0; jsb_acc = 0; inf_seen = 0;
    end
  endtask

  function automatic logic [PROB_W-1:0] pick_prob();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return PROB_W'($urandom);
      2: return PROB_W'(1) << PROB_FRAC_BITS;
      3: return PROB_W'($urandom_range(1, 255));
      4: return '1;
      default: return PROB_W'($urandom_range(0, 1 << PROB_FRAC_BITS));
    endcase
  endfunction

  task automatic add_pair(logic [PROB_W-1:0] a, logic [PROB_W-1:0] b, logic fin);
    pair_t p;
    p.p1 = a; p.p2 = b; p.last = fin;
    pending_pairs.push_back(p);
  endtask

  // acceptance on both channels
  always @(posedge clk) begin
    if (rst) begin
      idle_cycles <= 0;
    end else begin
      if (item_valid && !item_stall) begin
        fold_pair(prob_first, prob_second, last_item);
        req_taken = 1;
      end
      if (result_valid && !result_stall) begin
        if (expected_dists.size() == 0) begin
          $display("%0t: unexpected result hel=%h kl=%h js=%h inf=%b", $time,
                   hellinger_dist, kl_divergence, js_divergence, kl_infinite);
          mismatches++;
        end else begin
          dist_t e;
          e = expected_dists.pop_front();
          if (hellinger_dist !== e.hel) begin
            $display("%0t: hellinger expected %h actual %h", $time, e.hel, hellinger_dist);
            mismatches++;
          end
          if (kl_divergence !== e.kl) begin
            $display("%0t: kl expected %h actual %h", $time, e.kl, kl_divergence);
            mismatches++;
          end
          if (js_divergence !== e.js) begin
            $display("%0t: js expected %h actual %h", $time, e.js, js_divergence);
            mismatches++;
          end
          if (kl_infinite !== e.inf) begin
            $display("%0t: kl_infinite expected %b actual %b", $time, e.inf, kl_infinite);
            mismatches++;
          end
        end
      end
      if ((item_valid && !item_stall) || (result_valid && !result_stall)) begin
        idle_cycles <= 0;
      end else if (idle_cycles + 1 >= WATCHDOG_LIMIT) begin
        $display("probability_divergence_accumulator_core verification failed");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  // request driver with idle bursts, none near the end
  always @(negedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (!item_valid || req_taken) begin
      req_taken = 0;
      if (send_gap > 0) begin
        send_gap--;
        item_valid <= 1'b0;
      end else if (pending_pairs.size() == 0) begin
        item_valid <= 1'b0;
      end else if (pending_pairs.size() > QUIET_ITEMS && $urandom_range(0, 7) == 0) begin
        send_gap = $urandom_range(0, 17);
        item_valid <= 1'b0;
      end else begin
        pair_t p;
        p = pending_pairs.pop_front();
        prob_first <= p.p1;
        prob_second <= p.p2;
        last_item <= p.last;
        item_valid <= 1'b1;
      end
    end
  end

  always @(negedge clk) begin
    if (rst || pending_pairs.size() <= QUIET_ITEMS) begin
      recv_gap = 0;
      result_stall <= 1'b0;
    end else if (recv_gap > 0) begin
      recv_gap--;
      result_stall <= 1'b1;
    end else if ($urandom_range(0, 15) == 0) begin
      recv_gap = $urandom_range(0, 17);
      result_stall <= 1'b1;
    end else begin
      result_stall <= 1'b0;
    end
  end

  initial begin
    int n;
    // corners: zeros, one, field maximum, infinite kl, one-pair vectors
    add_pair('0, '0, 1'b1);
    add_pair(PROB_W'(1) << PROB_FRAC_BITS, PROB_W'(1) << PROB_FRAC_BITS, 1'b1);
    add_pair('1, '0, 1'b1);
    add_pair('0, '1, 1'b1);
    add_pair(PROB_W'(1) << PROB_FRAC_BITS, '0, 1'b0);
    add_pair(PROB_W'(1), PROB_W'(1), 1'b0);
    add_pair('1, '1, 1'b1);
    add_pair(PROB_W'(1), '1, 1'b0);
    add_pair('1, PROB_W'(1), 1'b1);
    add_pair(PROB_W'(1) << 23, PROB_W'(1) << 23, 1'b0);
    add_pair(PROB_W'(3) << 22, PROB_W'(1) << 22, 1'b0);
    add_pair('0, PROB_W'(1) << PROB_FRAC_BITS, 1'b1);
    add_pair(PROB_W'(1), '0, 1'b0);
    add_pair('0, '0, 1'b0);
    add_pair(PROB_W'(12345), PROB_W'(6789012), 1'b1);
    // random vectors, mostly short, always closed by a last pair
    while (pending_pairs.size() < 1600) begin
      n = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 8);
      for (int i = 0; i < n; i++)
        add_pair(pick_prob(), pick_prob(), i == n - 1 || $urandom_range(0, 49) == 0);
    end
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    wait (pending_pairs.size() == 0 && !item_valid && expected_dists.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && expected_dists.size() == 0) begin
      $display("probability_divergence_accumulator_core verification clean");
    end else begin
      $display("probability_divergence_accumulator_core verification failed");
    end
    $finish;
  end

endmodule
